// ----- design/mf3_pkg.sv -----
`timescale 1ns / 1ps

package mf3_pkg;

	// Field and register widths
	localparam int PIX_W = 8;
	localparam int ROW_W = 16;
	localparam int WCFG_W = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 1;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int QUEUE_DEPTH = 4;

	// Smallest frame dimension the filter works on
	localparam int MIN_DIM = 3;

	// Register reset values
	localparam logic [WCFG_W-1:0] WIDTH_RESET = 11'd640;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd480;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// Pixel values a job may emit: the window center (or its median), the pixel
	// at the right border, the one on the bottom row and the bottom-right corner
	typedef struct packed {
		pix_t center;
		pix_t right_px;
		pix_t below_px;
		pix_t corner_px;
	} pix_set_t;

	typedef struct packed {
		logic use_med;
		logic at_right;
		logic at_bottom;
	} job_flags_t;

	typedef struct packed {
		logic at_right;
		logic at_bottom;
	} emit_flags_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

endpackage

// ----- design/mf3_front.sv -----
`timescale 1ns / 1ps

module mf3_front import mf3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic [PIX_W-1:0]      pixel_in,
	input  logic                  adv,
	output logic                  valid_s2,
	output logic [2:0][2:0][PIX_W-1:0] win,
	output pix_set_t              set_s2,
	output job_flags_t            flags_s2,
	output logic [XW-1:0]         col_s2,
	output logic [ROW_W-1:0]      row_s2
);

	localparam logic [XW-1:0] W_MIN_LAST = XW'(MIN_DIM - 1);
	localparam logic [XW-1:0] W_MAX_LAST = XW'(MAX_WIDTH - 1);
	localparam logic [ROW_W-1:0] H_MIN_LAST = ROW_W'(MIN_DIM - 1);

	logic [WCFG_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [XW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [XW-1:0] w_last;
	logic [ROW_W-1:0] h_last;
	logic accept;

	logic valid_s1;
	logic [XW-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	pix_t pix_s1;

	// Line memory: upper byte two rows up, lower byte one row up
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] line_rd_q;

	pix_t right_s2;
	pix_t corner_s2;
	logic [2:0][2:0][PIX_W-1:0] win_q;

	assign accept = pix_valid && adv;
	assign pix_stall = !adv;

	// Clamp the frame size to the supported range
	always_comb begin
		if (width_q < WCFG_W'(MIN_DIM))
			w_last = W_MIN_LAST;
		else if (int'(width_q) > MAX_WIDTH)
			w_last = W_MAX_LAST;
		else
			w_last = XW'(width_q - WCFG_W'(1));
		if (height_q < ROW_W'(MIN_DIM))
			h_last = H_MIN_LAST;
		else
			h_last = height_q - ROW_W'(1);
	end

	// Hold the registers and advance the raster position; a write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: width_q <= cfg_data[WCFG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == w_last) begin
				col_q <= '0;
				row_q <= (row_q == h_last) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// Read the column on accept, write it back one stage later
	always_ff @(posedge clk) begin
		if (accept)
			line_rd_q <= line_mem[col_q];
		if (adv && valid_s1)
			line_mem[col_s1] <= {line_rd_q[PIX_W-1:0], pix_s1};
	end

	// Stage 1 and stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1 && (row_s1 != '0) && (col_s1 != '0);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col_q;
			row_s1 <= row_q;
			pix_s1 <= pixel_in;
		end
	end

	// Shift the window and classify the beat
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= line_rd_q[2*PIX_W-1:PIX_W];
			win_q[1][2] <= line_rd_q[PIX_W-1:0];
			win_q[2][2] <= pix_s1;
			right_s2 <= line_rd_q[PIX_W-1:0];
			corner_s2 <= pix_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			flags_s2.use_med <= (row_s1 > ROW_W'(1)) && (col_s1 > XW'(1));
			flags_s2.at_right <= (col_s1 == w_last);
			flags_s2.at_bottom <= (row_s1 == h_last);
		end
	end

	assign win = win_q;
	assign set_s2.center = win_q[1][1];
	assign set_s2.right_px = right_s2;
	assign set_s2.below_px = win_q[2][1];
	assign set_s2.corner_px = corner_s2;

endmodule

// ----- design/mf3_median.sv -----
`timescale 1ns / 1ps

module mf3_median import mf3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  valid_s2,
	input  logic [2:0][2:0][PIX_W-1:0] win,
	input  pix_set_t              set_s2,
	input  job_flags_t            flags_s2,
	input  logic [XW-1:0]         col_s2,
	input  logic [ROW_W-1:0]      row_s2,
	output logic                  valid_s5,
	output pix_set_t              set_s5,
	output emit_flags_t           eflags_s5,
	output logic [XW-1:0]         col_s5,
	output logic [ROW_W-1:0]      row_s5
);

	logic valid_s3, valid_s4;
	logic [2:0][PIX_W-1:0] lo_s3, md_s3, hi_s3;
	pix_t mlo_s4, mmd_s4, mhi_s4;
	pix_set_t set_s3, set_s4;
	job_flags_t flags_s3, flags_s4;
	logic [XW-1:0] col_s3, col_s4;
	logic [ROW_W-1:0] row_s3, row_s4;

	// Advance the valid bits with the shared enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Sort each window row, reduce across rows, pick the median of three or the center
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				lo_s3[i] <= min3(win[i][0], win[i][1], win[i][2]);
				md_s3[i] <= med3(win[i][0], win[i][1], win[i][2]);
				hi_s3[i] <= max3(win[i][0], win[i][1], win[i][2]);
			end
			set_s3 <= set_s2;
			flags_s3 <= flags_s2;
			col_s3 <= col_s2;
			row_s3 <= row_s2;

			mlo_s4 <= max3(lo_s3[0], lo_s3[1], lo_s3[2]);
			mmd_s4 <= med3(md_s3[0], md_s3[1], md_s3[2]);
			mhi_s4 <= min3(hi_s3[0], hi_s3[1], hi_s3[2]);
			set_s4 <= set_s3;
			flags_s4 <= flags_s3;
			col_s4 <= col_s3;
			row_s4 <= row_s3;

			set_s5.center <= flags_s4.use_med ? med3(mlo_s4, mmd_s4, mhi_s4)
				: set_s4.center;
			set_s5.right_px <= set_s4.right_px;
			set_s5.below_px <= set_s4.below_px;
			set_s5.corner_px <= set_s4.corner_px;
			eflags_s5.at_right <= flags_s4.at_right;
			eflags_s5.at_bottom <= flags_s4.at_bottom;
			col_s5 <= col_s4;
			row_s5 <= row_s4;
		end
	end

endmodule

// ----- design/mf3_queue.sv -----
`timescale 1ns / 1ps

module mf3_queue import mf3_pkg::*; #(
	parameter int DW = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          full,
	output logic          empty
);

	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [DW-1:0] slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == FULL_COUNT);
	assign empty = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ----- design/mf3_back.sv -----
`timescale 1ns / 1ps

module mf3_back import mf3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  pix_set_t         head_set,
	input  emit_flags_t      head_flags,
	input  logic [XW-1:0]    head_col,
	input  logic [ROW_W-1:0] head_row,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [PIX_W-1:0] pixel_out,
	output logic [XW-1:0]    out_x,
	output logic [ROW_W-1:0] out_y,
	output logic             run_last
);

	typedef enum logic [1:0] {
		RES_CENTER,
		RES_RIGHT,
		RES_BELOW,
		RES_CORNER
	} res_kind_t;

	res_kind_t kind_q;
	res_kind_t kind_next;
	logic last_res;
	logic take;

	// Pick the next result of the job, or mark this one as its last
	always_comb begin
		kind_next = RES_CENTER;
		last_res = 1'b1;
		case (kind_q)
			RES_CENTER: begin
				if (head_flags.at_right) begin
					kind_next = RES_RIGHT;
					last_res = 1'b0;
				end else if (head_flags.at_bottom) begin
					kind_next = RES_BELOW;
					last_res = 1'b0;
				end
			end
			RES_RIGHT: begin
				if (head_flags.at_bottom) begin
					kind_next = RES_BELOW;
					last_res = 1'b0;
				end
			end
			RES_BELOW: begin
				if (head_flags.at_right) begin
					kind_next = RES_CORNER;
					last_res = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Drive the result beat from the queue head
	always_comb begin
		case (kind_q)
			RES_RIGHT: begin
				pixel_out = head_set.right_px;
				out_x = head_col;
				out_y = head_row - ROW_W'(1);
			end
			RES_BELOW: begin
				pixel_out = head_set.below_px;
				out_x = head_col - XW'(1);
				out_y = head_row;
			end
			RES_CORNER: begin
				pixel_out = head_set.corner_px;
				out_x = head_col;
				out_y = head_row;
			end
			default: begin
				pixel_out = head_set.center;
				out_x = head_col - XW'(1);
				out_y = head_row - ROW_W'(1);
			end
		endcase
	end

	assign res_valid = head_valid;
	assign run_last = last_res;
	assign take = res_valid && !res_stall;
	assign pop = take && last_res;

	// Step through the results of the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kind_q <= RES_CENTER;
		else if (take)
			kind_q <= last_res ? RES_CENTER : kind_next;
	end

`ifndef SYNTH
	a_mid_job_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q != RES_CENTER) |-> head_valid)
		else $error("result sequence running without a queued job");

	a_right_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == RES_RIGHT) |-> head_flags.at_right)
		else $error("right-border result on a job not at the row end");

	a_corner_needs_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == RES_CORNER) |-> (head_flags.at_right && head_flags.at_bottom))
		else $error("corner result on a job not at the frame end");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(take && run_last) |=> (kind_q == RES_CENTER))
		else $error("sequence did not restart after the last result");
`endif

endmodule

// ----- design/median_filter_3x3.sv -----
`timescale 1ns / 1ps

// 3x3 median filter over an 8-bit grayscale frame streamed in raster order.
// The block takes one pixel per clock. Interior pixels come out as the median
// of their 3x3 neighborhood, pixels on the outer rows and columns come out
// unchanged, each tagged with its column and row. A pixel's result appears
// once the pixel one row down and one column right has been taken, so results
// trail the input by a line plus a pixel. The input at a row end yields an
// extra result for the right border, and inputs on the last row yield the
// bottom-row results too, up to four in all, with run_last set on the last
// one. The result port moves one beat per clock while res_stall is low, so
// sustained input rate is one pixel per clock except at row ends and on the
// last row, where the extra results drain through a QDEPTH-entry job queue
// and the input stalls once it fills. The first result an input releases
// is offered after the line memory read on the accepting edge, the window
// update, three median stages and the queue write. Any register write
// restarts the frame at column 0, row 0; write only while idle. The line
// memory is always rewritten before it is read for a result, so it needs
// no clearing after reset and the block takes pixels right away.
module median_filter_3x3 import mf3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int QDEPTH = QUEUE_DEPTH,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic [PIX_W-1:0]      pixel_in,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [PIX_W-1:0]      pixel_out,
	output logic [XW-1:0]         out_x,
	output logic [ROW_W-1:0]      out_y,
	output logic                  run_last
);

	localparam int QW = $bits(pix_set_t) + $bits(emit_flags_t) + XW + ROW_W;

	logic adv;
	logic valid_s2;
	logic [2:0][2:0][PIX_W-1:0] win;
	pix_set_t set_s2;
	job_flags_t flags_s2;
	logic [XW-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;

	logic valid_s5;
	pix_set_t set_s5;
	emit_flags_t eflags_s5;
	logic [XW-1:0] col_s5;
	logic [ROW_W-1:0] row_s5;

	logic q_full, q_empty, q_push, q_pop;
	logic [QW-1:0] q_push_data, q_pop_data;

	pix_set_t head_set;
	emit_flags_t head_flags;
	logic [XW-1:0] head_col;
	logic [ROW_W-1:0] head_row;

	// The front pipeline moves as a whole while the queue has room
	assign adv = !q_full;
	assign q_push = adv && valid_s5;
	assign q_push_data = {set_s5, eflags_s5, col_s5, row_s5};
	assign {head_set, head_flags, head_col, head_row} = q_pop_data;

	mf3_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel_in(pixel_in),
		.adv(adv),
		.valid_s2(valid_s2),
		.win(win),
		.set_s2(set_s2),
		.flags_s2(flags_s2),
		.col_s2(col_s2),
		.row_s2(row_s2)
	);

	mf3_median #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_median (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.valid_s2(valid_s2),
		.win(win),
		.set_s2(set_s2),
		.flags_s2(flags_s2),
		.col_s2(col_s2),
		.row_s2(row_s2),
		.valid_s5(valid_s5),
		.set_s5(set_s5),
		.eflags_s5(eflags_s5),
		.col_s5(col_s5),
		.row_s5(row_s5)
	);

	mf3_queue #(
		.DW(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_push_data),
		.pop(q_pop),
		.pop_data(q_pop_data),
		.full(q_full),
		.empty(q_empty)
	);

	mf3_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(!q_empty),
		.head_set(head_set),
		.head_flags(head_flags),
		.head_col(head_col),
		.head_row(head_row),
		.pop(q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.pixel_out(pixel_out),
		.out_x(out_x),
		.out_y(out_y),
		.run_last(run_last)
	);

endmodule

// ----- tb/tb_median_filter_3x3.sv -----
`timescale 1ns / 1ps

module tb_median_filter_3x3;
	import mf3_pkg::*;

	localparam int XW = $clog2(DEF_MAX_WIDTH);
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_PIXELS = 240;
	localparam int DIRECTED_N = 24;
	// three small frames: alternating extremes, a mixed frame, then a partial one
	localparam logic [DIRECTED_N*8-1:0] DIRECTED_PX = {
		8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd128, 8'd1, 8'd254,
		8'd200, 8'd100, 8'd50, 8'd25, 8'd12, 8'd6};

	typedef struct packed {
		pix_t              pixel;
		logic [XW-1:0]     x;
		logic [ROW_W-1:0]  y;
		logic              last;
	} filt_res_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pix_t                  pixel_in = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	pix_t                  pixel_out;
	logic [XW-1:0]         out_x;
	logic [ROW_W-1:0]      out_y;
	logic                  run_last;

	// filter state as the stream has seen it so far
	pix_t              row_above [DEF_MAX_WIDTH];
	pix_t              row_above2 [DEF_MAX_WIDTH];
	pix_t              win [3][3];
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic [WCFG_W-1:0] width_reg;
	logic [ROW_W-1:0]  height_reg;

	pix_t      raster_q [$];
	filt_res_t due_results [$];
	int        bad_beats = 0;

	median_filter_3x3 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel_in  (pixel_in),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.pixel_out (pixel_out),
		.out_x     (out_x),
		.out_y     (out_y),
		.run_last  (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned frame_width(input logic [WCFG_W-1:0] w);
		if (w < MIN_DIM) return MIN_DIM;
		if (w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned frame_height(input logic [ROW_W-1:0] h);
		return (h < MIN_DIM) ? MIN_DIM : h;
	endfunction

	// fifth smallest of the nine window cells
	function automatic pix_t neighborhood_median();
		pix_t v [9];
		pix_t t;
		int   k;
		int   j;
		for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3];
		for (k = 1; k < 9; k++) begin
			t = v[k];
			j = k - 1;
			while (j >= 0 && v[j] > t) begin
				v[j + 1] = v[j];
				j--;
			end
			v[j + 1] = t;
		end
		return v[4];
	endfunction

	function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		if (idx == REG_IMAGE_WIDTH) width_reg = val[WCFG_W-1:0];
		else height_reg = val;
		col_pos = 0;
		row_pos = 0;
	endfunction

	// shift the window, update the line stores, queue the results this pixel releases
	function automatic void take_pixel(input pix_t p);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int          n;
		pix_t        up2;
		pix_t        up1;
		filt_res_t   found [4];
		w = frame_width(width_reg);
		h = frame_height(height_reg);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = row_pos;
		up2 = row_above2[c];
		up1 = row_above[c];
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = up2;
		win[1][2] = up1;
		win[2][2] = p;
		row_above2[c] = up1;
		row_above[c] = p;
		n = 0;
		if (r >= 1 && c >= 1) begin
			found[n] = '{(r >= 2 && c >= 2) ? neighborhood_median() : win[1][1],
				XW'(c - 1), ROW_W'(r - 1), 1'b0};
			n = n + 1;
			if (c == w - 1) begin
				found[n] = '{up1, XW'(w - 1), ROW_W'(r - 1), 1'b0};
				n = n + 1;
			end
			if (r == h - 1) begin
				found[n] = '{win[2][1], XW'(c - 1), ROW_W'(r), 1'b0};
				n = n + 1;
				if (c == w - 1) begin
					found[n] = '{p, XW'(w - 1), ROW_W'(r), 1'b0};
					n = n + 1;
				end
			end
			found[n - 1].last = 1'b1;
			for (int k = 0; k < n; k++) due_results.push_back(found[k]);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endfunction

	function automatic pix_t rand_pixel();
		case ($urandom_range(0, 3))
			0: return pix_t'($urandom_range(0, 3));
			1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// write one register while the stream is idle
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		set_reg(idx, val);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// hold until every pixel is in and every result is out
	task automatic await_quiet();
		while (raster_q.size() != 0 || pix_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		await_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pixel driver: bursts of random length with random gaps
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pixel_in <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (pix_valid && !pix_stall) take_pixel(pixel_in);
			if (!pix_valid || !pix_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					pix_valid <= 1'b0;
				end else if (raster_q.size() != 0) begin
					pix_valid <= 1'b1;
					pixel_in <= raster_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// result stall pattern: free stretches, some long, then short holds
	int unsigned hold_left;
	int unsigned free_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
			free_left <= 0;
		end else if (free_left != 0) begin
			res_stall <= 1'b0;
			free_left <= free_left - 1;
		end else if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			res_stall <= 1'b0;
			hold_left <= $urandom_range(1, 7);
			free_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 5);
		end
	end

	// compare each result beat with the oldest pending one
	filt_res_t want;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				if (bad_beats < 10)
					$display("%0t: unexpected result pix=%0d x=%0d y=%0d last=%0b",
						$realtime, pixel_out, out_x, out_y, run_last);
				bad_beats++;
			end else begin
				want = due_results.pop_front();
				if (pixel_out !== want.pixel || out_x !== want.x || out_y !== want.y
						|| run_last !== want.last) begin
					if (bad_beats < 10)
						$display({"%0t: mismatch exp pix=%0d x=%0d y=%0d last=%0b,",
							" got pix=%0d x=%0d y=%0d last=%0b"},
							$realtime, want.pixel, want.x, want.y, want.last,
							pixel_out, out_x, out_y, run_last);
					bad_beats++;
				end
			end
		end
	end

	// stop if neither channel moves for too long
	int unsigned quiet_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned w_set;
		int unsigned h_set;
		int unsigned ew;
		int unsigned eh;
		int unsigned n_px;
		int unsigned random_px;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		foreach (row_above[i]) begin
			row_above[i] = '0;
			row_above2[i] = '0;
		end
		foreach (win[i, j]) win[i][j] = '0;
		col_pos = 0;
		row_pos = 0;
		random_px = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: a short run on the first row releases nothing
		for (int k = 0; k < 20; k++) raster_q.push_back(rand_pixel());
		settle();

		// undersized geometry acts as 3x3; pause for a full drain after the first frame
		program_reg(REG_IMAGE_WIDTH, 16'd1);
		program_reg(REG_IMAGE_HEIGHT, 16'd0);
		for (int k = 0; k < 9; k++) raster_q.push_back(DIRECTED_PX[(DIRECTED_N-1-k)*8 +: 8]);
		await_quiet();
		for (int k = 9; k < DIRECTED_N; k++)
			raster_q.push_back(DIRECTED_PX[(DIRECTED_N-1-k)*8 +: 8]);
		settle();

		// upper data bits beyond the width register are dropped
		program_reg(REG_IMAGE_WIDTH, 16'hF803);
		program_reg(REG_IMAGE_HEIGHT, 16'd3);
		for (int k = 0; k < 40; k++) raster_q.push_back(rand_pixel());
		settle();

		// random geometries, mostly whole frames, some partial
		while (random_px < RANDOM_PIXELS) begin
			case ($urandom_range(0, 7))
				0: w_set = $urandom_range(0, 2);
				1: w_set = $urandom_range(17, 40);
				default: w_set = $urandom_range(3, 16);
			endcase
			case ($urandom_range(0, 7))
				0: h_set = $urandom_range(0, 2);
				1: h_set = ($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(7, 20);
				default: h_set = $urandom_range(3, 6);
			endcase
			program_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_set));
			program_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_set));
			ew = frame_width(WCFG_W'(w_set));
			eh = frame_height(ROW_W'(h_set));
			if (ew * eh <= 120 && $urandom_range(0, 3) != 0)
				n_px = ew * eh * $urandom_range(1, 2) + $urandom_range(0, 2 * ew);
			else
				n_px = $urandom_range(10, 80);
			for (int k = 0; k < n_px; k++) raster_q.push_back(rand_pixel());
			random_px += n_px;
			settle();
		end

		// widest row, tallest frame: a short run on the first row releases nothing
		program_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(DEF_MAX_WIDTH));
		program_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
		for (int k = 0; k < 30; k++) raster_q.push_back(rand_pixel());
		settle();

		// oversized width clamps to the widest row
		program_reg(REG_IMAGE_WIDTH, 16'h07FF);
		program_reg(REG_IMAGE_HEIGHT, 16'd2);
		for (int k = 0; k < 30; k++) raster_q.push_back(rand_pixel());
		settle();

		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (bad_beats == 0 && due_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/mf3_pkg.sv
design/mf3_front.sv
design/mf3_median.sv
design/mf3_queue.sv
design/mf3_back.sv
design/median_filter_3x3.sv
tb/tb_median_filter_3x3.sv
